// ===== design/psc_pkg.sv =====
// ---------------------------------------------------------------------------
// psc_pkg: shared types and constants of the pressure sensor conditioner
// Field widths, sensor kind codes, supply timer and fault constants, and the
// structs that carry one converted sample and one result beat.
// ---------------------------------------------------------------------------
package psc_pkg;

   localparam int RAW_W          = 16;
   localparam int DATA_W         = 14;
   localparam int CD_W           = 6;
   localparam int FC_W           = 3;
   localparam int RING_DEPTH_DEF = 5;

   typedef enum logic {
      KIND_1BAR   = 1'b0,
      KIND_2P5BAR = 1'b1
   } kind_type;

   localparam logic [RAW_W-1:0] RAW_BAD_LOW  = 16'h0000;
   localparam logic [RAW_W-1:0] RAW_BAD_HIGH = 16'hFFFF;

   // Supply timer, two's complement; it rests at CD_IDLE after the first repower, at CD_ZERO after later ones.
   localparam logic signed [CD_W-1:0] CD_IDLE    = -6'sd1;
   localparam logic signed [CD_W-1:0] CD_ZERO    = 6'sd0;
   localparam logic signed [CD_W-1:0] OFF_TICKS  = 6'sd20;
   localparam logic signed [CD_W-1:0] REPOWER_AT = 6'sd5;

   localparam logic [FC_W-1:0] FAULT_LIMIT = 3'd3;
   localparam logic [FC_W-1:0] FAULT_SAT   = 3'd4;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     bad;
   } sample_type;

   typedef struct packed {
      logic                     sample_taken;
      logic                     fault_seen;
      logic                     sensor_power;
      logic                     pressure_valid;
      logic signed [DATA_W-1:0] pressure;
   } result_type;

endpackage

// ===== design/pressure_sensor_conditioner.sv =====
// ---------------------------------------------------------------------------
// pressure_sensor_conditioner: fault-guarded trimmed-mean pressure filter
// Converts each raw reading, manages the sensor supply after faults and
// delivers the held trimmed mean of the last samples with status flags.
// ---------------------------------------------------------------------------
//  channel  dir  ports                                   payload
//  req      in   req_tvalid req_tready req_tdata[15:0]    raw_reading
//  rsp      out  rsp_tvalid rsp_tready rsp_tdata[23:0]    pressure, flags
//                rsp_tuser                                pressure_valid
//  csr      in   csr_valid csr_ready csr_data             sensor_kind
//
// One beat per cycle is sustained while rsp is not stalled; a beat accepted on req
// passes the input register and the result register before it leaves on rsp.
// Reset clears the supply, fault and ring control state; no clearing pass.
// A stalled rsp holds its beat while the input register still takes one more;
// req_tready drops only when both registers are full and rsp is stalled.
// ---------------------------------------------------------------------------
module pressure_sensor_conditioner #(
   parameter int RING_DEPTH = psc_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] raw_reading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [13:0] pressure, [14] sensor_power,
                                    // [15] fault_seen, [16] sample_taken
   output logic        rsp_tuser,   // [0] pressure_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // [0] sensor_kind
);

   localparam int PAD_W = 24 - psc_pkg::DATA_W - 3;

   psc_pkg::kind_type    kind_ff;
   logic                 in_valid_ff;
   psc_pkg::sample_type  in_sample_ff;
   psc_pkg::sample_type  sample_in;
   logic                 rsp_valid_ff;
   psc_pkg::result_type  rsp_result_ff;
   psc_pkg::result_type  result_in;
   logic                 step;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   psc_convert u_convert (
      .raw   (req_tdata),
      .kind  (kind_ff),
      .value (sample_in.value),
      .bad   (sample_in.bad)
   );

   psc_core #(
      .RING_DEPTH (RING_DEPTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (in_sample_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= psc_pkg::KIND_1BAR;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            kind_ff <= psc_pkg::kind_type'(csr_data);
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= sample_in;
      end
      if (step) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.pressure_valid;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_result_ff.sample_taken,
                        rsp_result_ff.fault_seen, rsp_result_ff.sensor_power,
                        rsp_result_ff.pressure};

   // A tick either stores a sample or reports a fault, never both.
   a_fault_or_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_result_ff.fault_seen && rsp_result_ff.sample_taken))
      else $error("fault and sample reported on the same beat");

   // A fault always cuts the supply in the same tick.
   a_fault_cuts_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result_ff.fault_seen) |-> !rsp_result_ff.sensor_power)
      else $error("fault beat shows the supply on");

   // Samples are only taken with the supply on.
   a_taken_powered: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result_ff.sample_taken) |-> rsp_result_ff.sensor_power)
      else $error("sample taken with the supply off");

   // An invalid result carries a zero pressure.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_result_ff.pressure == '0))
      else $error("invalid beat with nonzero pressure");

   // The input side only backs up when the result side is stalled.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && in_valid_ff))
      else $error("req stalled without a stalled result");

endmodule

// ===== design/psc_convert.sv =====
// ---------------------------------------------------------------------------
// psc_convert: raw reading to millibar
// Applies the linear formula of the selected sensor kind, truncating toward
// zero, and flags the two fault words.
// ---------------------------------------------------------------------------
module psc_convert (
   input  logic [psc_pkg::RAW_W-1:0]          raw,
   input  psc_pkg::kind_type                  kind,
   output logic signed [psc_pkg::DATA_W-1:0]  value,
   output logic                               bad
);

   localparam int CVT_W     = 20;
   localparam int RECIP_W   = 21;
   localparam int CVT_SHIFT = 25;
   localparam int PROD_W    = CVT_W - 1 + RECIP_W;

   localparam logic signed [CVT_W-1:0] OFFSET_1BAR   = 20'sd16500;
   localparam logic signed [CVT_W-1:0] OFFSET_2P5BAR = 20'sd10714;
   // ceil(2^25 / 27) and ceil(2^25 / 54); exact for magnitudes below 2^19.
   localparam logic [RECIP_W-1:0] RECIP_1BAR   = 21'd1242757;
   localparam logic [RECIP_W-1:0] RECIP_2P5BAR = 21'd621379;

   logic signed [CVT_W-1:0]    diff;
   logic signed [CVT_W-1:0]    scaled;
   logic        [CVT_W-1:0]    scaled_neg;
   logic        [CVT_W-2:0]    mag;
   logic        [RECIP_W-1:0]  recip;
   logic        [PROD_W-1:0]   prod;
   logic [psc_pkg::DATA_W-1:0] quot;

   always_comb begin
      unique case (kind)
         psc_pkg::KIND_1BAR: begin
            diff   = $signed({4'b0000, raw}) - OFFSET_1BAR;
            scaled = diff <<< 1;
            recip  = RECIP_1BAR;
         end
         psc_pkg::KIND_2P5BAR: begin
            // 3500 / 27000 reduces to 7 / 54.
            diff   = $signed({4'b0000, raw}) - OFFSET_2P5BAR;
            scaled = (diff <<< 3) - diff;
            recip  = RECIP_2P5BAR;
         end
         default: begin
            diff   = '0;
            scaled = '0;
            recip  = RECIP_1BAR;
         end
      endcase
   end

   assign scaled_neg = -scaled;
   assign mag   = scaled[CVT_W-1] ? scaled_neg[CVT_W-2:0] : scaled[CVT_W-2:0];
   assign prod  = PROD_W'(mag) * PROD_W'(recip);
   assign quot  = prod[CVT_SHIFT +: psc_pkg::DATA_W];
   assign value = scaled[CVT_W-1] ? $signed(-quot) : $signed(quot);
   assign bad   = (raw == psc_pkg::RAW_BAD_LOW) || (raw == psc_pkg::RAW_BAD_HIGH);

endmodule

// ===== design/psc_trim_mean.sv =====
// ---------------------------------------------------------------------------
// psc_trim_mean: trimmed mean of the sample window
// Sums the window, drops its minimum and maximum and divides the rest by the
// depth less two, truncating toward zero.
// ---------------------------------------------------------------------------
module psc_trim_mean #(
   parameter int DEPTH = psc_pkg::RING_DEPTH_DEF
) (
   input  logic signed [psc_pkg::DATA_W-1:0] entries [DEPTH],
   output logic signed [psc_pkg::DATA_W-1:0] mean
);

   localparam int SUM_W = psc_pkg::DATA_W + $clog2(DEPTH) + 1;
   localparam int DIV   = DEPTH - 2;
   localparam int K     = SUM_W;
   // Rounded-up reciprocal; the error stays below 2^K for every magnitude.
   localparam logic [K:0] RECIP = (K+1)'(((1 << K) + DIV - 1) / DIV);

   logic signed [psc_pkg::DATA_W-1:0] mn;
   logic signed [psc_pkg::DATA_W-1:0] mx;
   logic signed [SUM_W-1:0]           sum;
   logic signed [SUM_W-1:0]           trimmed;
   logic        [SUM_W-1:0]           trimmed_neg;
   logic        [SUM_W-2:0]           mag;
   logic        [2*SUM_W-1:0]         prod;
   logic        [psc_pkg::DATA_W-1:0] quot;

   always_comb begin
      mn  = entries[0];
      mx  = entries[0];
      sum = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sum = sum + SUM_W'(entries[i]);
         if (entries[i] < mn) begin
            mn = entries[i];
         end
         if (entries[i] > mx) begin
            mx = entries[i];
         end
      end
   end

   assign trimmed     = sum - SUM_W'(mn) - SUM_W'(mx);
   assign trimmed_neg = -trimmed;
   assign mag  = trimmed[SUM_W-1] ? trimmed_neg[SUM_W-2:0] : trimmed[SUM_W-2:0];
   assign prod = (2*SUM_W)'(mag) * (2*SUM_W)'(RECIP);
   assign quot = prod[K +: psc_pkg::DATA_W];
   assign mean = trimmed[SUM_W-1] ? $signed(-quot) : $signed(quot);

endmodule

// ===== design/psc_core.sv =====
// ---------------------------------------------------------------------------
// psc_core: supply control, fault counting and sample ring
// Holds the per-sensor state, updates it for each sample that is stepped in
// and forms that sample's result beat.
// ---------------------------------------------------------------------------
module psc_core #(
   parameter int RING_DEPTH = psc_pkg::RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  psc_pkg::sample_type  sample,
   output psc_pkg::result_type  result
);

   localparam int DATA_W = psc_pkg::DATA_W;
   localparam int IDX_W  = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   logic                              power_ff,  power_in;
   logic signed [psc_pkg::CD_W-1:0]   cd_ff,     cd_in;
   logic        [psc_pkg::FC_W-1:0]   fc_ff,     fc_in;
   logic        [IDX_W-1:0]           idx_ff,    idx_in;
   logic                              full_ff,   full_in;
   logic signed [DATA_W-1:0]          held_ff,   held_in;
   logic                              hvalid_ff, hvalid_in;
   logic signed [DATA_W-1:0]          ring_ff [RING_DEPTH];

   logic signed [DATA_W-1:0]          window [RING_DEPTH];
   logic signed [DATA_W-1:0]          mean;
   logic signed [psc_pkg::CD_W-1:0]   cd_dec;
   logic        [psc_pkg::FC_W-1:0]   fc_next;
   logic                              fault;
   logic                              taken;

   // The mean sees the ring as it stands after this sample is written.
   always_comb begin
      for (int i = 0; i < RING_DEPTH; i++) begin
         window[i] = (IDX_W'(i) == idx_ff) ? sample.value : ring_ff[i];
      end
   end

   psc_trim_mean #(
      .DEPTH (RING_DEPTH)
   ) u_trim_mean (
      .entries (window),
      .mean    (mean)
   );

   assign cd_dec  = (cd_ff != psc_pkg::CD_IDLE) ? cd_ff - 1'b1 : cd_ff;
   assign fc_next = (fc_ff < psc_pkg::FAULT_SAT) ? fc_ff + 1'b1 : fc_ff;

   always_comb begin
      power_in  = power_ff;
      cd_in     = cd_ff;
      fc_in     = fc_ff;
      idx_in    = idx_ff;
      full_in   = full_ff;
      held_in   = held_ff;
      hvalid_in = hvalid_ff;
      fault     = 1'b0;
      taken     = 1'b0;
      priority if (!power_ff) begin
         cd_in = cd_dec;
         if (cd_dec <= psc_pkg::REPOWER_AT) begin
            // Repower tick: restart the ring and drop the reading.
            power_in  = 1'b1;
            idx_in    = '0;
            full_in   = 1'b0;
            held_in   = '0;
            hvalid_in = 1'b0;
         end
      end else if (cd_ff > psc_pkg::CD_ZERO) begin
         cd_in = cd_ff - 1'b1;
      end else if (sample.bad) begin
         fault    = 1'b1;
         power_in = 1'b0;
         cd_in    = psc_pkg::OFF_TICKS;
         fc_in    = fc_next;
         if (fc_next > psc_pkg::FAULT_LIMIT) begin
            held_in   = '0;
            hvalid_in = 1'b0;
         end
      end else begin
         taken = 1'b1;
         fc_in = '0;
         if (idx_ff == IDX_LAST) begin
            idx_in  = '0;
            full_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
         if (full_in) begin
            held_in   = mean;
            hvalid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 1'b0;
         cd_ff     <= psc_pkg::CD_ZERO;
         fc_ff     <= '0;
         idx_ff    <= '0;
         full_ff   <= 1'b0;
         held_ff   <= '0;
         hvalid_ff <= 1'b0;
      end else if (step) begin
         power_ff  <= power_in;
         cd_ff     <= cd_in;
         fc_ff     <= fc_in;
         idx_ff    <= idx_in;
         full_ff   <= full_in;
         held_ff   <= held_in;
         hvalid_ff <= hvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && taken) begin
         ring_ff[idx_ff] <= sample.value;
      end
   end

   assign result.sample_taken   = taken;
   assign result.fault_seen     = fault;
   assign result.sensor_power   = power_in;
   assign result.pressure_valid = hvalid_in;
   assign result.pressure       = hvalid_in ? held_in : '0;

endmodule

// ===== verif/pressure_sensor_conditioner_tb.sv =====
// ---------------------------------------------------------------------------
// pressure_sensor_conditioner_tb: self-checking bench of the sensor conditioner
// Streams raw readings through the block under both sensor kinds and checks
// every result beat against a cycle-free predictor of the supply timer, the
// fault counter and the trimmed-mean ring, with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pressure_sensor_conditioner_tb;

   localparam int DATA_W          = psc_pkg::DATA_W;
   localparam int RAW_W           = psc_pkg::RAW_W;
   localparam int RING_DEPTH_DEF  = psc_pkg::RING_DEPTH_DEF;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 3;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int SETTLE_CYCLES   = 4;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int BURST_PHASE     = 2;
   localparam int HOLD_PHASE      = 4;
   localparam int BURST_LEN       = 130;
   localparam int ALL_FAULTS      = 100;
   localparam int RSP_W           = 24;

   localparam int POWER_BIT = DATA_W;
   localparam int FAULT_BIT = DATA_W + 1;
   localparam int TAKEN_BIT = DATA_W + 2;

   // Linear conversion constants of the two sensor kinds.
   localparam int ONE_BAR_OFFSET = 16500;
   localparam int ONE_BAR_GAIN   = 2;
   localparam int ONE_BAR_DIV    = 27;
   localparam int TWO_BAR_OFFSET = 10714;
   localparam int TWO_BAR_GAIN   = 3500;
   localparam int TWO_BAR_DIV    = 30000 - 3000;

   localparam psc_pkg::kind_type PHASE_KIND [NUM_PHASES] =
      '{psc_pkg::KIND_1BAR, psc_pkg::KIND_2P5BAR, psc_pkg::KIND_1BAR,
        psc_pkg::KIND_2P5BAR, psc_pkg::KIND_1BAR};
   localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 52, 0, 27, 0};
   localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 52, 27, 0};

   localparam logic [RAW_W-1:0] DIRECTED_2P5BAR [6] =
      '{16'h1234, 16'h0001, 16'hFFFE, 16'd10714, 16'd10714, 16'h8000};
   localparam logic [RAW_W-1:0] DIRECTED_1BAR [8] =
      '{16'h0001, 16'hFFFE, 16'd16500, 16'd16500, 16'h5A5A, 16'h7FFF,
        psc_pkg::RAW_BAD_LOW, psc_pkg::RAW_BAD_HIGH};

   class pressure_scoreboard;
      psc_pkg::kind_type   kind;
      bit                  power_on;
      int                  countdown;
      int                  fault_count;
      int                  ring [RING_DEPTH_DEF];
      int                  ring_index;
      bit                  ring_full;
      int                  held_pressure;
      bit                  held_valid;
      psc_pkg::result_type expected_q [$];
      int                  error_count;

      function new();
         kind          = psc_pkg::KIND_1BAR;
         power_on      = 1'b0;
         countdown     = 0;
         fault_count   = 0;
         ring_index    = 0;
         ring_full     = 1'b0;
         held_pressure = 0;
         held_valid    = 1'b0;
         error_count   = 0;
         foreach (ring[i]) ring[i] = 0;
      endfunction

      // Advances the predicted state by one accepted reading.
      function void note_reading(logic [RAW_W-1:0] raw);
         int                  r;
         int                  idx;
         int                  mn;
         int                  mx;
         int                  sum;
         bit                  fault;
         bit                  taken;
         bit                  repowered;
         psc_pkg::result_type e;
         r         = int'(raw);
         fault     = 1'b0;
         taken     = 1'b0;
         repowered = 1'b0;
         if (!power_on) begin
            if (countdown > int'(psc_pkg::CD_IDLE)) countdown--;
            // The repower tick clears the ring and ignores its reading.
            if (countdown <= int'(psc_pkg::REPOWER_AT)) begin
               ring_index    = 0;
               ring_full     = 1'b0;
               held_valid    = 1'b0;
               held_pressure = 0;
               power_on      = 1'b1;
               repowered     = 1'b1;
            end
         end
         if (!repowered && power_on) begin
            if (countdown > 0) begin
               countdown--;
            end else if (raw == psc_pkg::RAW_BAD_LOW || raw == psc_pkg::RAW_BAD_HIGH) begin
               fault     = 1'b1;
               power_on  = 1'b0;
               countdown = int'(psc_pkg::OFF_TICKS);
               if (fault_count < int'(psc_pkg::FAULT_SAT)) fault_count++;
               if (fault_count > int'(psc_pkg::FAULT_LIMIT)) begin
                  held_valid    = 1'b0;
                  held_pressure = 0;
               end
            end else begin
               idx         = (ring_index < RING_DEPTH_DEF) ? ring_index : 0;
               fault_count = 0;
               taken       = 1'b1;
               if (kind == psc_pkg::KIND_1BAR)
                  ring[idx] = ((r - ONE_BAR_OFFSET) * ONE_BAR_GAIN) / ONE_BAR_DIV;
               else
                  ring[idx] = (TWO_BAR_GAIN * (r - TWO_BAR_OFFSET)) / TWO_BAR_DIV;
               idx++;
               if (idx >= RING_DEPTH_DEF) begin
                  ring_full = 1'b1;
                  idx       = 0;
               end
               ring_index = idx;
               if (ring_full) begin
                  mn  = ring[0];
                  mx  = ring[0];
                  sum = 0;
                  foreach (ring[i]) begin
                     sum += ring[i];
                     if (ring[i] < mn) mn = ring[i];
                     if (ring[i] > mx) mx = ring[i];
                  end
                  held_pressure = (sum - mn - mx) / (RING_DEPTH_DEF - 2);
                  held_valid    = 1'b1;
               end
            end
         end
         e.pressure       = held_valid ? DATA_W'(held_pressure) : '0;
         e.pressure_valid = held_valid;
         e.sensor_power   = power_on;
         e.fault_seen     = fault;
         e.sample_taken   = taken;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, int expected, int actual);
         if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            error_count++;
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] data, logic user);
         psc_pkg::result_type e;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing pending: tdata %h tuser %b", data, user);
            error_count++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("pressure", int'(e.pressure), int'($signed(data[DATA_W-1:0])));
         compare_field("pressure_valid", int'(e.pressure_valid), int'(user));
         compare_field("sensor_power", int'(e.sensor_power), int'(data[POWER_BIT]));
         compare_field("fault_seen", int'(e.fault_seen), int'(data[FAULT_BIT]));
         compare_field("sample_taken", int'(e.sample_taken), int'(data[TAKEN_BIT]));
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RAW_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic             csr_data   = 1'b0;

   logic             hold_request   = 1'b0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               idle_cycles    = 0;

   pressure_scoreboard sb = new();

   pressure_sensor_conditioner #(
      .RING_DEPTH(RING_DEPTH_DEF)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_tready   <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("pressure_sensor_conditioner verification failed");
      $finish;
   end

   task automatic send_reading(input logic [RAW_W-1:0] raw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      sb.note_reading(raw);
   endtask

   task automatic write_kind(input psc_pkg::kind_type k);
      csr_valid <= 1'b1;
      csr_data  <= logic'(k);
      do @(posedge clock); while (!csr_ready);
      sb.kind    = k;
      csr_valid <= 1'b0;
   endtask

   // Stops offering and waits until every pending result beat has left.
   task automatic flush_results();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] random_reading(int fault_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < fault_pct)
         return $urandom_range(0, 1) ? psc_pkg::RAW_BAD_HIGH : psc_pkg::RAW_BAD_LOW;
      // A narrow band makes equal ring entries and ties for min and max likely.
      if (roll < fault_pct + 30)
         return RAW_W'($urandom_range(ONE_BAR_OFFSET - 400, ONE_BAR_OFFSET + 400));
      return RAW_W'($urandom_range(1, 16'hFFFE));
   endfunction

   initial begin
      int seg_left;
      int fault_pct;
      int n_items;
      seg_left  = 0;
      fault_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first beat after reset only brings the supply up.
      write_kind(psc_pkg::KIND_2P5BAR);
      foreach (DIRECTED_2P5BAR[i]) send_reading(DIRECTED_2P5BAR[i]);
      flush_results();
      // The ring carries over a kind change; the fault at the end keeps the
      // held value, and the all-ones beat after it arrives with the supply off.
      write_kind(psc_pkg::KIND_1BAR);
      foreach (DIRECTED_1BAR[i]) send_reading(DIRECTED_1BAR[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         flush_results();
         send_idle_pct  = PHASE_SEND_IDLE[phase];
         recv_stall_pct = PHASE_RECV_STALL[phase];
         write_kind(PHASE_KIND[phase]);
         n_items = ITEMS_PER_PHASE;
         seg_left = 0;
         // An unbroken run of faults drives the fault count into saturation.
         if (phase == BURST_PHASE) begin
            fault_pct = ALL_FAULTS;
            seg_left  = BURST_LEN;
            n_items  += BURST_LEN;
         end
         if (phase == HOLD_PHASE) hold_request <= 1'b1;
         for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
               case ($urandom_range(0, 9))
                  0: begin
                     fault_pct = ALL_FAULTS;
                     seg_left  = $urandom_range(20, 40);
                  end
                  1, 2: begin
                     fault_pct = 0;
                     seg_left  = $urandom_range(20, 60);
                  end
                  default: begin
                     fault_pct = 3;
                     seg_left  = $urandom_range(20, 60);
                  end
               endcase
            end
            send_reading(random_reading(fault_pct));
            seg_left--;
         end
      end
      flush_results();

      if (sb.error_count == 0 && sb.expected_q.size() == 0)
         $display("pressure_sensor_conditioner verification clean");
      else
         $display("pressure_sensor_conditioner verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/psc_pkg.sv
design/psc_convert.sv
design/psc_trim_mean.sv
design/psc_core.sv
design/pressure_sensor_conditioner.sv
verif/pressure_sensor_conditioner_tb.sv
